FILE: rtl/separable_gaussian_blur_rgb_defines.svh
// Shared assertion macros for the blur block checkers.
`ifndef SEPARABLE_GAUSSIAN_BLUR_RGB_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_RGB_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define SGBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgbr check failed");

// Next-cycle implication, off while in reset.
`define SGBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgbr check failed");

// Next-cycle implication that also looks at reset itself.
`define SGBR_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sgbr check failed");

`endif

FILE: rtl/sgbr_pkg.sv
package sgbr_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_MAX_RADIUS = 4;

  localparam int PIX_W   = 8;
  localparam int WORD_W  = 3 * PIX_W;
  localparam int VS_W    = 18;
  localparam int COEF_W  = 18;
  localparam int NCOEF   = 5;
  localparam int RW      = 3;
  localparam int QDEPTH  = 4;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 18;

  localparam logic [VS_W-1:0]  VS_MAX  = '1;
  localparam logic [PIX_W-1:0] PIX_MAX = '1;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_RADIUS,
    REG_COEF_C,
    REG_COEF_1,
    REG_COEF_2,
    REG_COEF_3,
    REG_COEF_4
  } cfg_reg_t;

  typedef struct packed {
    logic [10:0]                   width;
    logic [12:0]                   height;
    logic [RW-1:0]                 radius;
    logic [NCOEF-1:0][COEF_W-1:0]  coef;
  } cfg_t;

endpackage

FILE: rtl/sgbr_ram.sv
module sgbr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: rtl/sgbr_queue.sv
module sgbr_queue #(
  parameter int W = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int LW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [W-1:0]  push_data,
  input  logic          pop,
  output logic [W-1:0]  head,
  output logic          not_empty,
  output logic [LW-1:0] level
);

  logic [W-1:0]  store [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;

  assign head      = store[rp];
  assign not_empty = (level != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      store[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (push && !pop) begin
        level <= level + LW'(1);
      end else if (pop && !push) begin
        level <= level - LW'(1);
      end
    end
  end

endmodule

FILE: rtl/sgbr_front.sv
module sgbr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 4,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int WIN   = 2 * MAX_RADIUS + 1,
  localparam int JOB_W = 3 * CW + 1 + WIN * 3 * sgbr_pkg::VS_W,
  localparam int LW    = $clog2(sgbr_pkg::QDEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sgbr_pkg::cfg_t       cfg,
  input  logic                 cfg_wr,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic [LW-1:0]        q_level,
  output logic                 push,
  output logic [JOB_W-1:0]     push_data
);

  import sgbr_pkg::*;

  localparam int WEW  = $clog2(MAX_WIDTH + 1);
  localparam int HEW  = $clog2(MAX_HEIGHT + 1);
  localparam int JW   = $clog2(MAX_HEIGHT + MAX_RADIUS);
  localparam int RING = 2 * MAX_RADIUS;
  localparam int BW   = $clog2(RING);
  localparam int NT   = 2 * MAX_RADIUS + 1;
  localparam int PW   = COEF_W + PIX_W;
  localparam int SW   = PW + $clog2(NT);

  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [RW-1:0]  r_eff;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = WEW'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = HEW'(1);
    end else if (32'(cfg.height) > MAX_HEIGHT) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(cfg.height);
    end
    if (32'(cfg.radius) > MAX_RADIUS && MAX_RADIUS < 4) begin
      r_eff = RW'(MAX_RADIUS);
    end else if (cfg.radius > RW'(4)) begin
      r_eff = RW'(4);
    end else begin
      r_eff = cfg.radius;
    end
  end

  // ---- accept stage: position counters, row store access, tap rows
  logic [CW-1:0] col, col_next;
  logic [JW-1:0] row, row_next;
  logic [BW-1:0] ring, ring_next;
  logic [CW-1:0] cc;
  logic [JW-1:0] jj;
  logic [BW-1:0] jr;
  logic          acc;
  logic          v1, v2;

  assign s_tready = (32'(q_level) + 32'(v1) + 32'(v2)) < QDEPTH;
  assign acc      = s_tvalid && s_tready;

  logic                  shift0, emit0, frm0, pix_row0;
  logic [CW-1:0]         x0_0, x1_0;
  logic [NT-1:0][BW-1:0] bank0;
  logic [NT-1:0]         own0, act0;

  always_comb begin
    int t, p, d, b, tap_dist;
    if (32'(col) >= 32'(w_eff) || 32'(row) >= 32'(h_eff) + 32'(r_eff)) begin
      cc = '0;
      jj = '0;
      jr = '0;
    end else begin
      cc = col;
      jj = row;
      jr = ring;
    end

    col_next  = cc + CW'(1);
    row_next  = jj;
    ring_next = jr;
    if (32'(cc) == 32'(w_eff) - 1) begin
      col_next  = '0;
      row_next  = jj + JW'(1);
      ring_next = (jr == BW'(RING - 1)) ? '0 : jr + BW'(1);
      if (32'(jj) + 1 >= 32'(h_eff) + 32'(r_eff)) begin
        row_next  = '0;
        ring_next = '0;
      end
    end

    pix_row0 = 32'(jj) < 32'(h_eff);
    shift0   = 32'(jj) >= 32'(r_eff);
    frm0     = 32'(jj) == 32'(h_eff) - 1 + 32'(r_eff);
    x0_0     = '0;
    x1_0     = '0;
    emit0    = 1'b0;
    if (32'(cc) == 32'(w_eff) - 1) begin
      x1_0  = cc;
      x0_0  = (32'(cc) >= 32'(r_eff)) ? cc - CW'(r_eff) : '0;
      emit0 = shift0;
    end else if (32'(cc) >= 32'(r_eff)) begin
      x0_0  = cc - CW'(r_eff);
      x1_0  = cc - CW'(r_eff);
      emit0 = shift0;
    end

    // vertical tap rows are clamped to the frame, then mapped onto the ring
    for (int k = 0; k < NT; k++) begin
      t        = k - MAX_RADIUS;
      tap_dist = (t < 0) ? -t : t;
      p        = int'(jj) - int'(r_eff) + t;
      if (p > int'(h_eff) - 1) p = int'(h_eff) - 1;
      if (p < 0) p = 0;
      d = int'(jj) - p;
      b = int'(jr) + RING - d;
      if (b >= RING) b = b - RING;
      act0[k]  = tap_dist <= int'(r_eff);
      own0[k]  = (d == 0);
      bank0[k] = BW'(b);
    end
  end

  logic [RING-1:0][WORD_W-1:0] bank_q;

  for (genvar g = 0; g < RING; g++) begin : g_bank
    sgbr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk   (clk),
      .we    (acc && pix_row0 && !cfg_wr && (jr == BW'(g))),
      .waddr (cc),
      .wdata (s_tdata),
      .raddr (cc),
      .rdata (bank_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col  <= '0;
      row  <= '0;
      ring <= '0;
    end else if (acc) begin
      col  <= col_next;
      row  <= row_next;
      ring <= ring_next;
    end
  end

  // ---- stage 1: row store data back, per-tap products
  logic [CW-1:0]         c1, x0_1, x1_1;
  logic                  shift1, emit1, frm1;
  logic [WORD_W-1:0]     pix1;
  logic [NT-1:0][BW-1:0] bank1;
  logic [NT-1:0]         own1, act1;
  logic [NT-1:0][2:0][PW-1:0] prod1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= acc && !cfg_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      c1     <= cc;
      x0_1   <= x0_0;
      x1_1   <= x1_0;
      shift1 <= shift0;
      emit1  <= emit0;
      frm1   <= frm0;
      pix1   <= s_tdata;
      bank1  <= bank0;
      own1   <= own0;
      act1   <= act0;
    end
  end

  always_comb begin
    int tap_dist;
    logic [WORD_W-1:0] word;
    logic [COEF_W-1:0] cf;
    for (int k = 0; k < NT; k++) begin
      tap_dist = (k < MAX_RADIUS) ? MAX_RADIUS - k : k - MAX_RADIUS;
      cf       = (tap_dist < NCOEF) ? cfg.coef[tap_dist] : '0;
      word     = own1[k] ? pix1 : bank_q[bank1[k]];
      for (int ch = 0; ch < 3; ch++) begin
        prod1[k][ch] = act1[k] ? PW'(cf) * PW'(word[PIX_W*ch +: PIX_W]) : '0;
      end
    end
  end

  // ---- stage 2: vertical sums, column window, job out
  logic [CW-1:0]              c2, x0_2, x1_2;
  logic                       shift2, emit2, frm2;
  logic [NT-1:0][2:0][PW-1:0] prod2;
  logic [WIN-1:0][2:0][VS_W-1:0] win, win_next;
  logic [2:0][VS_W-1:0]       vnew;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      c2     <= c1;
      x0_2   <= x0_1;
      x1_2   <= x1_1;
      shift2 <= shift1;
      emit2  <= emit1;
      frm2   <= frm1;
      prod2  <= prod1;
    end
  end

  always_comb begin
    logic [SW-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int k = 0; k < NT; k++) begin
        s = s + SW'(prod2[k][ch]);
      end
      // 8.16 down to 10.8
      vnew[ch] = (s[SW-1:8] > (SW-8)'(VS_MAX)) ? VS_MAX : s[VS_W+7:8];
    end
    win_next = win;
    if (v2 && shift2) begin
      win_next[0] = vnew;
      for (int k = 1; k < WIN; k++) begin
        win_next[k] = win[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else begin
      win <= win_next;
    end
  end

  assign push      = v2 && emit2;
  assign push_data = {win_next, frm2, x1_2, x0_2, c2};

endmodule

FILE: rtl/sgbr_back.sv
module sgbr_back #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int WIN   = 2 * MAX_RADIUS + 1,
  localparam int JOB_W = 3 * CW + 1 + WIN * 3 * sgbr_pkg::VS_W
) (
  input  logic             clk,
  input  logic             rst,
  input  sgbr_pkg::cfg_t   cfg,
  input  logic [JOB_W-1:0] head,
  input  logic             q_valid,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  import sgbr_pkg::*;

  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int NT  = 2 * MAX_RADIUS + 1;
  localparam int IW  = $clog2(WIN);
  localparam int PW  = COEF_W + VS_W;
  localparam int SW  = PW + $clog2(NT);

  logic [WEW-1:0] w_eff;
  logic [RW-1:0]  r_eff;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = WEW'(1);
    end else if (32'(cfg.width) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(cfg.width);
    end
    if (32'(cfg.radius) > MAX_RADIUS && MAX_RADIUS < 4) begin
      r_eff = RW'(MAX_RADIUS);
    end else if (cfg.radius > RW'(4)) begin
      r_eff = RW'(4);
    end else begin
      r_eff = cfg.radius;
    end
  end

  logic [CW-1:0]                 c_h, x0_h, x1_h;
  logic                          frm_h;
  logic [WIN-1:0][2:0][VS_W-1:0] win_h;

  assign c_h   = head[CW-1:0];
  assign x0_h  = head[2*CW-1:CW];
  assign x1_h  = head[3*CW-1:2*CW];
  assign frm_h = head[3*CW];
  assign win_h = head[JOB_W-1:3*CW+1];

  // one output column per cycle out of the job at the queue head, while the output is not stalled
  logic          busy;
  logic [CW-1:0] xcur, x;
  logic          last, issue, adv_out, b1_ready, v_b1;

  assign adv_out  = !m_tvalid || m_tready;
  assign b1_ready = !v_b1 || adv_out;
  assign issue    = q_valid && b1_ready;
  assign x        = busy ? xcur : x0_h;
  assign last     = (x == x1_h);
  assign pop      = issue && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (issue) begin
      busy <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      xcur <= x + CW'(1);
    end
  end

  logic [NT-1:0][2:0][PW-1:0] prod0, prod_b;
  logic                       last_b, frm_b;

  always_comb begin
    int t, tap_dist, qi, idx;
    logic [COEF_W-1:0] cf;
    for (int k = 0; k < NT; k++) begin
      t        = k - MAX_RADIUS;
      tap_dist = (t < 0) ? -t : t;
      cf       = (tap_dist < NCOEF) ? cfg.coef[tap_dist] : '0;
      qi       = int'(x) + t;
      if (qi > int'(w_eff) - 1) qi = int'(w_eff) - 1;
      if (qi < 0) qi = 0;
      idx = (qi <= int'(c_h)) ? int'(c_h) - qi : 0;
      if (idx > WIN - 1) idx = WIN - 1;
      for (int ch = 0; ch < 3; ch++) begin
        prod0[k][ch] = (tap_dist <= int'(r_eff)) ?
                       PW'(cf) * PW'(win_h[IW'(idx)][ch]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0;
    end else if (b1_ready) begin
      v_b1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_b <= prod0;
      last_b <= last;
      frm_b  <= frm_h && (32'(x) == 32'(w_eff) - 1);
    end
  end

  logic [2:0][PIX_W-1:0] pix_o;

  always_comb begin
    logic [SW-1:0] s;
    for (int ch = 0; ch < 3; ch++) begin
      s = '0;
      for (int k = 0; k < NT; k++) begin
        s = s + SW'(prod_b[k][ch]);
      end
      // 10.24 down to an integer
      pix_o[ch] = (s[SW-1:24] > (SW-24)'(PIX_MAX)) ? PIX_MAX : s[31:24];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv_out) begin
      m_tvalid <= v_b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && v_b1) begin
      m_tdata <= pix_o;
      m_tlast <= last_b;
      m_tuser <= frm_b;
    end
  end

endmodule

FILE: rtl/separable_gaussian_blur_rgb.sv
// Separable Gaussian blur on an RGB pixel stream, vertical pass then horizontal.
// Input stream (s_*): one pixel per transaction in raster order, then
// radius*width flush transactions; the position counters alone decide which
// is which. Output stream (m_*): blurred pixels in raster order, tlast on the
// last pixel caused by an input, tuser on the bottom right pixel of the frame.
// Config channel (cfg_*): always ready; any write restarts the frame position.
// Throughput, while m_tready stays high: one input per cycle mid-row, where
// every input gives one result. At a row end the back end emits up to
// radius+1 results, one per cycle; the 4-entry job queue takes the jobs
// behind that burst, then the input side stalls until the back end catches up.
// Path to the output register: row store read (stage 1), tap products
// (stage 2), vertical sum (job queue), horizontal products (product register).
// Row store: 2*MAX_RADIUS RAM banks of MAX_WIDTH pixels, one per buffered row.
// Reset clears counters, the column window and all valids; the row store is
// not cleared (only rows written earlier in the frame are read).
// When m_tready is low the output register holds, the back end stops, and the
// input side keeps accepting until the job queue cannot take what is in flight.
module separable_gaussian_blur_rgb #(
  parameter int MAX_WIDTH  = sgbr_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sgbr_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = sgbr_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // red_in, green_in, blue_in
  input  logic                        s_tuser,   // command
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // red_out, green_out, blue_out
  output logic                        m_tlast,
  output logic                        m_tuser,   // frame_done
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sgbr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sgbr_pkg::CFG_DW-1:0] cfg_data
);

  import sgbr_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WIN   = 2 * MAX_RADIUS + 1;
  localparam int JOB_W = 3 * CW + 1 + WIN * 3 * VS_W;
  localparam int LW    = $clog2(QDEPTH + 1);

  cfg_t cfg;
  logic cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 11'd640;
      cfg.height <= 13'd480;
      cfg.radius <= RW'(1);
      // center tap 1.0, distance taps zero
      cfg.coef   <= (NCOEF * COEF_W)'(65536);
    end else if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  cfg.width   <= cfg_data[10:0];
        REG_HEIGHT: cfg.height  <= cfg_data[12:0];
        REG_RADIUS: cfg.radius  <= cfg_data[RW-1:0];
        REG_COEF_C: cfg.coef[0] <= cfg_data[COEF_W-1:0];
        REG_COEF_1: cfg.coef[1] <= cfg_data[COEF_W-1:0];
        REG_COEF_2: cfg.coef[2] <= cfg_data[COEF_W-1:0];
        REG_COEF_3: cfg.coef[3] <= cfg_data[COEF_W-1:0];
        REG_COEF_4: cfg.coef[4] <= cfg_data[COEF_W-1:0];
        default:    cfg.width   <= cfg.width;
      endcase
    end
  end

  logic             push, pop, q_valid;
  logic [JOB_W-1:0] push_data, head;
  logic [LW-1:0]    q_level;

  sgbr_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_level   (q_level),
    .push      (push),
    .push_data (push_data)
  );

  sgbr_queue #(
    .W     (JOB_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .level     (q_level)
  );

  sgbr_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .q_valid  (q_valid),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: rtl/sgbr_checker.sv
`include "separable_gaussian_blur_rgb_defines.svh"

module sgbr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [23:0]                 s_tdata,
  input logic                        s_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [23:0]                 m_tdata,
  input logic                        m_tlast,
  input logic                        m_tuser,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [sgbr_pkg::CFG_IW-1:0] cfg_index,
  input logic [sgbr_pkg::CFG_DW-1:0] cfg_data
);

  // a stalled output transaction keeps its valid and its payload
  `SGBR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
  `SGBR_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

  // the frame's final pixel always closes the burst of its input
  `SGBR_ASSERT_NOW(a_frame_last, m_tvalid && m_tuser, m_tlast)

  // nothing is offered in the cycle after reset
  `SGBR_ASSERT_RST(a_rst_quiet, rst, !m_tvalid)

endmodule

bind separable_gaussian_blur_rgb sgbr_checker u_sgbr_checker (.*);
